/* sv/fht_pkg.sv */
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types and constants for the FNV-1a linear probe hash table unit.
// ----------------------------------------------------------------------------
package fht_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int MAX_KEY_BYTES = 8;
	localparam int LEN_W = 4;

	localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
	localparam logic [31:0] HASH_MULT = 32'h01000193;

	localparam logic [1:0] OP_SET      = 2'd0;
	localparam logic [1:0] OP_GET      = 2'd1;
	localparam logic [1:0] OP_CONTAINS = 2'd2;
	localparam logic [1:0] OP_REMOVE   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] hash;
		logic [63:0] value;
		logic        bad;
	} req_t;

endpackage

/* sv/fnv1a_linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_hash_table_unit
// FNV-1a keyed hash table of 256 slots with linear probing.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. The front
// hashes the key one byte per cycle and then enqueues the request, and
// the probe engine reads the slot memory one slot per cycle: a hit ends
// the walk at the matching slot, while a miss or a new insert walks all
// 256 slots. The two run concurrently through a two-word queue. Each
// result appears for one cycle with done high and must be taken then. No
// clearing pass is needed after reset.
module fnv1a_linear_probe_hash_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_len,
	input  logic [63:0] value_word,
	output logic        done,
	output logic        found,
	output logic [7:0]  slot_index,
	output logic [63:0] value_out,
	output logic [1:0]  status,
	output logic [8:0]  count_out
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	fht_pkg::req_t push_req;
	fht_pkg::req_t pop_req;

	fht_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .key_bytes(key_bytes), .key_len(key_len),
		.value_word(value_word), .push(push), .push_req(push_req),
		.q_full(q_full)
	);

	fht_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_req(push_req),
		.full(q_full), .pop(pop), .pop_req(pop_req), .empty(q_empty)
	);

	fht_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(q_empty), .pop_req(pop_req),
		.pop(pop), .done(done), .found(found), .slot_index(slot_index),
		.value_out(value_out), .status(status), .count_out(count_out)
	);

	fht_count_mon u_mon (
		.clk(clk), .arst_n(arst_n), .done(done), .status(status),
		.found(found), .count_out(count_out)
	);

endmodule

/* sv/fht_front.sv */
// ----------------------------------------------------------------------------
// fht_front
// Accepts request words, hashes the key one byte per cycle, flags keys
// that cannot be stored or searched, and hands the request to the queue.
// ----------------------------------------------------------------------------
module fht_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [63:0]        key_bytes,
	input  logic [3:0]         key_len,
	input  logic [63:0]        value_word,
	output logic               push,
	output fht_pkg::req_t      push_req,
	input  logic               q_full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_HASH = 2'd1;
	localparam logic [1:0] F_HOLD = 2'd2;

	logic [1:0]                  state_q;
	logic [1:0]                  kind_q;
	logic [63:0]                 key_q;
	logic [63:0]                 val_q;
	logic [fht_pkg::LEN_W-1:0]   left_q;
	logic [31:0]                 h_q;
	logic                        zlen_q;
	logic [fht_pkg::LEN_W-1:0]   len_sat;
	logic [31:0]                 h_next;

	assign busy = (state_q != F_IDLE);
	assign len_sat = (key_len > fht_pkg::LEN_W'(fht_pkg::MAX_KEY_BYTES)) ?
		fht_pkg::LEN_W'(fht_pkg::MAX_KEY_BYTES) : key_len;
	assign h_next = (h_q ^ {24'd0, key_q[7:0]}) * fht_pkg::HASH_MULT;

	assign push = (state_q == F_HOLD) && !q_full;
	assign push_req.kind = kind_q;
	assign push_req.hash = h_q;
	assign push_req.value = val_q;
	assign push_req.bad = (kind_q == fht_pkg::OP_SET) ? (zlen_q || h_q == 32'd0)
		: (h_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (start) state_q <= (len_sat == '0) ? F_HOLD : F_HASH;
				F_HASH: if (left_q == fht_pkg::LEN_W'(1)) state_q <= F_HOLD;
				F_HOLD: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			kind_q <= kind;
			key_q <= key_bytes;
			val_q <= value_word;
			left_q <= len_sat;
			h_q <= fht_pkg::FNV_BASIS;
			zlen_q <= (len_sat == '0);
		end else if (state_q == F_HASH) begin
			h_q <= h_next;
			key_q <= key_q >> 8;
			left_q <= left_q - fht_pkg::LEN_W'(1);
		end
	end

endmodule

/* sv/fht_fifo.sv */
// ----------------------------------------------------------------------------
// fht_fifo
// Two-entry request queue between the hashing front and the probe engine.
// ----------------------------------------------------------------------------
module fht_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fht_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output fht_pkg::req_t pop_req,
	output logic          empty
);

	fht_pkg::req_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_req = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_req;
	end

endmodule

/* sv/fht_back.sv */
// ----------------------------------------------------------------------------
// fht_back
// Probe engine: walks the slot memories one slot per cycle from the home
// slot, finds the key or the first empty slot, then updates and reports.
// ----------------------------------------------------------------------------
module fht_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  fht_pkg::req_t pop_req,
	output logic          pop,
	output logic          done,
	output logic          found,
	output logic [7:0]    slot_index,
	output logic [63:0]   value_out,
	output logic [1:0]    status,
	output logic [8:0]    count_out
);

	localparam int IW = fht_pkg::IDX_W;
	localparam int CW = fht_pkg::CNT_W;
	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_PROBE = 2'd1;
	localparam logic [1:0] B_VREAD = 2'd2;
	localparam logic [1:0] B_OUT   = 2'd3;

	logic [31:0] hash_mem [fht_pkg::ENTRIES];
	logic [63:0] val_mem [fht_pkg::ENTRIES];
	logic [fht_pkg::ENTRIES-1:0] vld_q;

	logic [1:0]    state_q;
	fht_pkg::req_t req_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] count_q;
	logic          match_q;
	logic [IW-1:0] match_idx_q;
	logic          efound_q;
	logic [IW-1:0] eidx_q;

	logic          rd_v_s1;
	logic          rd_last_s1;
	logic [IW-1:0] rd_addr_s1;
	logic          rd_vld_s1;
	logic [31:0]   hash_rd_s1;
	logic [63:0]   val_rd_s1;

	logic          iss_v;
	logic [IW-1:0] iss_addr;
	logic          hit;
	logic          is_set;
	logic          set_new;
	logic          set_upd;
	logic          do_rem;

	assign pop = (state_q == B_IDLE) && !empty;
	assign iss_v = (state_q == B_PROBE) && !n_q[IW];
	assign iss_addr = req_q.hash[IW-1:0] + n_q[IW-1:0];
	assign hit = rd_vld_s1 && (hash_rd_s1 == req_q.hash);
	assign is_set = (req_q.kind == fht_pkg::OP_SET);
	assign set_upd = (state_q == B_OUT) && !req_q.bad && is_set && match_q;
	assign set_new = (state_q == B_OUT) && !req_q.bad && is_set && !match_q && efound_q;
	assign do_rem = (state_q == B_OUT) && !req_q.bad && match_q
		&& (req_q.kind == fht_pkg::OP_REMOVE);

	always_ff @(posedge clk) begin
		if (set_new) hash_mem[eidx_q] <= req_q.hash;
		hash_rd_s1 <= hash_mem[iss_addr];
	end

	always_ff @(posedge clk) begin
		if (set_new) val_mem[eidx_q] <= req_q.value;
		else if (set_upd) val_mem[match_idx_q] <= req_q.value;
		val_rd_s1 <= val_mem[match_idx_q];
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= iss_addr;
		rd_last_s1 <= (n_q == CW'(fht_pkg::ENTRIES - 1));
		rd_vld_s1 <= vld_q[iss_addr];
		if (pop) req_q <= pop_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			vld_q <= '0;
			count_q <= '0;
			n_q <= '0;
			match_q <= 1'b0;
			match_idx_q <= '0;
			efound_q <= 1'b0;
			eidx_q <= '0;
			rd_v_s1 <= 1'b0;
			done <= 1'b0;
			found <= 1'b0;
			slot_index <= '0;
			value_out <= '0;
			status <= fht_pkg::ST_OK;
			count_out <= '0;
		end else begin
			rd_v_s1 <= iss_v;
			done <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						n_q <= '0;
						match_q <= 1'b0;
						efound_q <= 1'b0;
						state_q <= pop_req.bad ? B_OUT : B_PROBE;
					end
				end
				B_PROBE: begin
					if (iss_v) n_q <= n_q + CW'(1);
					if (rd_v_s1) begin
						if (hit) begin
							match_q <= 1'b1;
							match_idx_q <= rd_addr_s1;
							state_q <= B_VREAD;
						end else begin
							if (!rd_vld_s1 && !efound_q) begin
								efound_q <= 1'b1;
								eidx_q <= rd_addr_s1;
							end
							if (rd_last_s1) state_q <= B_VREAD;
						end
					end
				end
				B_VREAD: state_q <= B_OUT;
				B_OUT: begin
					done <= 1'b1;
					found <= 1'b0;
					slot_index <= '0;
					value_out <= '0;
					count_out <= 9'(count_q);
					state_q <= B_IDLE;
					if (req_q.bad) begin
						status <= is_set ? fht_pkg::ST_INVALID : fht_pkg::ST_MISSING;
					end else if (is_set) begin
						if (match_q) begin
							found <= 1'b1;
							slot_index <= 8'(match_idx_q);
							status <= fht_pkg::ST_OK;
						end else if (efound_q) begin
							slot_index <= 8'(eidx_q);
							status <= fht_pkg::ST_OK;
							vld_q[eidx_q] <= 1'b1;
							count_q <= count_q + CW'(1);
							count_out <= 9'(count_q + CW'(1));
						end else begin
							status <= fht_pkg::ST_FULL;
						end
					end else if (!match_q) begin
						status <= fht_pkg::ST_MISSING;
					end else begin
						found <= 1'b1;
						slot_index <= 8'(match_idx_q);
						status <= fht_pkg::ST_OK;
						if (req_q.kind == fht_pkg::OP_GET) value_out <= val_rd_s1;
						if (do_rem) begin
							vld_q[match_idx_q] <= 1'b0;
							if (count_q != '0) begin
								count_q <= count_q - CW'(1);
								count_out <= 9'(count_q - CW'(1));
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_done_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == B_OUT))
		else $error("result strobe without finishing step");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(fht_pkg::ENTRIES))
		else $error("occupied count above capacity");
	a_new_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		set_new |-> !vld_q[eidx_q])
		else $error("insert into an occupied slot");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_PROBE || state_q == B_OUT))
		else $error("dequeue did not start a request");

endmodule

/* sv/fht_top_dummy_placeholder.sv */
// ----------------------------------------------------------------------------
// fht_count_mon
// Checks that the occupied count reported at the result port moves by at most
// one per result, and that a failed request neither changes it nor reports found.
// ----------------------------------------------------------------------------
module fht_count_mon (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       done,
	input  logic [1:0] status,
	input  logic       found,
	input  logic [8:0] count_out
);

	logic [8:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= '0;
		else if (done) last_q <= count_out;
	end

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count_out == last_q || count_out == last_q + 9'd1
		|| count_out == last_q - 9'd1))
		else $error("count moved by more than one");
	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fht_pkg::ST_OK) |-> (count_out == last_q))
		else $error("failed request changed the count");
	a_fail_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fht_pkg::ST_OK) |-> !found)
		else $error("failed request reports found");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FNV-1a linear probe hash table unit. A local
// copy of the table predicts every result word; results are matched in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG = 4000;

	typedef struct packed {
		logic        found;
		logic [7:0]  slot;
		logic [63:0] value;
		logic [1:0]  status;
		logic [8:0]  count;
	} table_resp_t;

	class table_scoreboard;
		logic [31:0] hashes [fht_pkg::ENTRIES];
		logic [63:0] values [fht_pkg::ENTRIES];
		logic [8:0]  occupied;
		table_resp_t pending [$];
		int          errors;
		int          checked;

		function new();
			for (int i = 0; i < fht_pkg::ENTRIES; i++) begin
				hashes[i] = '0;
				values[i] = '0;
			end
			occupied = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] fnv_hash(logic [63:0] kb, int len);
			logic [31:0] h;
			h = fht_pkg::FNV_BASIS;
			for (int i = 0; i < len; i++) begin
				h = h ^ {24'd0, kb[8*i +: 8]};
				h = h * fht_pkg::HASH_MULT;
			end
			return h;
		endfunction

		function int probe(logic [31:0] h, logic [31:0] target);
			int idx;
			idx = int'(h % fht_pkg::ENTRIES);
			for (int n = 0; n < fht_pkg::ENTRIES; n++) begin
				if (hashes[idx] == target)
					return idx;
				idx = (idx + 1) % fht_pkg::ENTRIES;
			end
			return -1;
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
				logic [63:0] vw);
			table_resp_t r;
			int len;
			int idx;
			logic [31:0] h;
			r = '0;
			r.status = fht_pkg::ST_OK;
			len = (kl > fht_pkg::MAX_KEY_BYTES) ? fht_pkg::MAX_KEY_BYTES : int'(kl);
			h = fnv_hash(kb, len);
			if (op == fht_pkg::OP_SET) begin
				if (len == 0 || h == 0) begin
					r.status = fht_pkg::ST_INVALID;
				end else begin
					idx = probe(h, h);
					if (idx >= 0) begin
						r.found = 1'b1;
						r.slot = idx[7:0];
						values[idx] = vw;
					end else begin
						idx = probe(h, 32'd0);
						if (idx < 0) begin
							r.status = fht_pkg::ST_FULL;
						end else begin
							r.slot = idx[7:0];
							hashes[idx] = h;
							values[idx] = vw;
							occupied = occupied + 1;
						end
					end
				end
			end else begin
				idx = (h == 0) ? -1 : probe(h, h);
				if (idx < 0) begin
					r.status = fht_pkg::ST_MISSING;
				end else begin
					r.found = 1'b1;
					r.slot = idx[7:0];
					if (op == fht_pkg::OP_GET)
						r.value = values[idx];
					else if (op == fht_pkg::OP_REMOVE) begin
						hashes[idx] = '0;
						values[idx] = '0;
						if (occupied > 0)
							occupied = occupied - 1;
					end
				end
			end
			r.count = occupied;
			pending.push_back(r);
		endfunction

		function void check_result(table_resp_t got);
			table_resp_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.found !== want.found || got.slot !== want.slot ||
					got.value !== want.value || got.status !== want.status ||
					got.count !== want.count) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: found %b/%b slot %0d/%0d value %h/%h",
						" status %0d/%0d count %0d/%0d"},
						want.found, got.found, want.slot, got.slot, want.value, got.value,
						want.status, got.status, want.count, got.count);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [63:0] key_bytes;
	logic [3:0]  key_len;
	logic [63:0] value_word;
	logic        done;
	logic        found;
	logic [7:0]  slot_index;
	logic [63:0] value_out;
	logic [1:0]  status;
	logic [8:0]  count_out;

	table_scoreboard sb;
	int idle_cycles;
	bit calm;
	logic [63:0] key_pool [32];

	fnv1a_linear_probe_hash_table_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.key_bytes(key_bytes), .key_len(key_len), .value_word(value_word),
		.done(done), .found(found), .slot_index(slot_index), .value_out(value_out),
		.status(status), .count_out(count_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result({found, slot_index, value_out, status, count_out});
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_word(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
			logic [63:0] vw);
		while (!calm && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		key_bytes <= kb;
		key_len <= kl;
		value_word <= vw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(op, kb, kl, vw);
	endtask

	task automatic send_pooled();
		logic [1:0] op;
		int r;
		r = $urandom_range(99);
		op = (r < 40) ? fht_pkg::OP_SET : (r < 60) ? fht_pkg::OP_GET :
			(r < 75) ? fht_pkg::OP_CONTAINS : fht_pkg::OP_REMOVE;
		if ($urandom_range(9) == 0)
			send_word(op, {$urandom, $urandom}, 4'($urandom_range(15)), {$urandom, $urandom});
		else
			send_word(op, key_pool[$urandom_range(31)], 4'($urandom_range(1, 8)),
				{$urandom, $urandom});
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind = fht_pkg::OP_SET;
		key_bytes = '0;
		key_len = '0;
		value_word = '0;
		idle_cycles = 0;
		calm = 1'b0;
		for (int i = 0; i < 32; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_word(fht_pkg::OP_GET, 64'd0, 4'd0, 64'd0);
		send_word(fht_pkg::OP_SET, 64'd0, 4'd0, 64'd1);
		send_word(fht_pkg::OP_SET, 64'd0, 4'd1, '1);
		send_word(fht_pkg::OP_SET, '1, 4'd8, 64'd0);
		send_word(fht_pkg::OP_SET, '1, 4'd15, 64'h0123_4567_89ab_cdef);
		send_word(fht_pkg::OP_GET, '1, 4'd8, 64'd0);
		send_word(fht_pkg::OP_GET, 64'd0, 4'd1, 64'd0);
		send_word(fht_pkg::OP_CONTAINS, '1, 4'd8, '1);
		send_word(fht_pkg::OP_CONTAINS, 64'h55, 4'd2, 64'd0);
		send_word(fht_pkg::OP_REMOVE, 64'd0, 4'd1, 64'd0);
		send_word(fht_pkg::OP_REMOVE, 64'd0, 4'd1, 64'd0);
		send_word(fht_pkg::OP_GET, 64'd0, 4'd1, 64'd0);
		send_word(fht_pkg::OP_REMOVE, 64'd0, 4'd0, 64'd0);
		send_word(fht_pkg::OP_SET, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 64'h5555_5555_5555_5555);
		send_word(fht_pkg::OP_GET, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 64'd0);
		send_word(fht_pkg::OP_SET, 64'h5555_5555_5555_5555, 4'd7, '1);
		drain();

		// fill the table to full, probe it while full, then remove the first 40 keys
		for (int i = 0; i < 262; i++)
			send_word(fht_pkg::OP_SET, {32'd0, 32'(i)}, 4'd4, {$urandom, $urandom});
		send_word(fht_pkg::OP_GET, {32'd0, 32'd5}, 4'd4, 64'd0);
		send_word(fht_pkg::OP_SET, 64'hdead_beef, 4'd8, 64'd7);
		send_word(fht_pkg::OP_CONTAINS, 64'hdead_beef, 4'd8, 64'd0);
		for (int i = 0; i < 40; i++)
			send_word(fht_pkg::OP_REMOVE, {32'd0, 32'(i)}, 4'd4, 64'd0);
		drain();

		calm = 1'b1;
		for (int i = 0; i < 80; i++)
			send_pooled();
		calm = 1'b0;
		for (int i = 0; i < 170; i++)
			send_pooled();

		drain();
		$display("covered %0d result words: invalid keys, full table, hits, misses, removes",
			sb.checked);
		$display("long keys saturated, random and pooled keys with random gaps");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
